// ===== hw/rtl/mse_pkg.sv =====
// Shared types, constants and the letter code table for the Morse segment encoder.
package mse_pkg;

  localparam int unsigned UnitW = 10;
  localparam int unsigned DurW  = 12;
  localparam int unsigned CharW = 8;

  localparam logic [UnitW-1:0] UnitReset = 10'd100;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChA     = 8'h41;
  localparam logic [CharW-1:0] ChZ     = 8'h5A;

  // one classified character waiting for the segment sequencer
  typedef struct packed {
    logic       is_space;
    logic [2:0] len;   // element count, 1..4 (0 for a space)
    logic [3:0] bits;  // bit i set = element i is a dah
  } mse_cmd_t;

  // element count per letter A..Z
  localparam logic [2:0] LetterLen [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // dah mask per letter A..Z, first element in bit 0
  localparam logic [3:0] LetterBits [26] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

endpackage

// ===== hw/rtl/morse_segment_encoder.sv =====
// Top level of the Morse segment encoder: unit register, front end, queue, sequencer.
//
// Input stream (s_axis_*): one ASCII character per word. Uppercase A..Z and
// space are encoded; every other code is accepted and dropped.
// Output stream (m_axis_*): one key-line segment per word, key level and
// duration in ms; tlast marks the final segment of a character.
// A letter of n elements gives 2n segments (tone, gap per element, the last
// gap 3 units), a space gives one 4-unit off segment.
// Timing: a character reaches the queue in the cycle it is accepted; the
// sequencer pops it into its command register once idle, and its segments
// pass through the output register. Segments then leave at one per cycle
// while the receiver is ready, with a pickup step between characters.
// The two-entry queue keeps taking characters while the sequencer works.
// A stalled receiver holds the output register; the sequencer and then the
// queue fill up and s_axis_tready drops.
// cfg_we_i writes unit_ms (reset 100); write only while the block is idle.
// Reset empties the queue and the output register.
module morse_segment_encoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mse_pkg::UnitW-1:0]   cfg_wdata_i,    // unit_ms
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] character
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,   // [0] key_on, [12:1] duration_ms
  output logic                        m_axis_tlast
);

  logic [mse_pkg::UnitW-1:0] unit_ms_q;

  logic              q_push, q_full, q_pop, q_empty;
  mse_pkg::mse_cmd_t q_wcmd, q_rcmd;

  // unit length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ms_q <= mse_pkg::UnitReset;
    end else if (cfg_we_i) begin
      unit_ms_q <= cfg_wdata_i;
    end
  end

  mse_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_wcmd)
  );

  mse_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_wcmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (q_rcmd)
  );

  mse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .unit_ms_i     (unit_ms_q),
    .q_empty_i     (q_empty),
    .q_cmd_i       (q_rcmd),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/mse_front.sv =====
// Front end: accepts characters, drops unencoded ones, looks up letter codes.
module mse_front (
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [mse_pkg::CharW-1:0]   s_axis_tdata,   // [7:0] character
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output mse_pkg::mse_cmd_t           q_cmd_o
);

  logic       is_space;
  logic       is_letter;
  logic [4:0] letter_idx;
  logic [mse_pkg::CharW-1:0] offs;

  assign s_axis_tready = !q_full_i;

  assign is_space   = (s_axis_tdata == mse_pkg::ChSpace);
  assign is_letter  = (s_axis_tdata >= mse_pkg::ChA) && (s_axis_tdata <= mse_pkg::ChZ);
  assign offs       = s_axis_tdata - mse_pkg::ChA;
  assign letter_idx = offs[4:0];

  always_comb begin
    q_cmd_o.is_space = is_space;
    q_cmd_o.len      = 3'd0;
    q_cmd_o.bits     = 4'd0;
    if (is_letter) begin
      q_cmd_o.len  = mse_pkg::LetterLen[letter_idx];
      q_cmd_o.bits = mse_pkg::LetterBits[letter_idx];
    end
  end

  // only encodable characters make it into the queue
  assign q_push_o = s_axis_tvalid && !q_full_i && (is_space || is_letter);

endmodule

// ===== hw/rtl/mse_fifo.sv =====
// Two-entry command queue between the front end and the segment sequencer.
module mse_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mse_pkg::mse_cmd_t push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output mse_pkg::mse_cmd_t pop_cmd_o
);

  mse_pkg::mse_cmd_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hw/rtl/mse_back.sv =====
// Back end: walks a character's elements, one segment per cycle when not stalled.
module mse_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mse_pkg::UnitW-1:0]   unit_ms_i,
  input  logic                        q_empty_i,
  input  mse_pkg::mse_cmd_t           q_cmd_i,
  output logic                        q_pop_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // [0] key_on, [12:1] duration_ms
  output logic                        m_axis_tlast
);

  mse_pkg::mse_cmd_t cmd_q, cmd_d;
  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  logic       gap_q, gap_d;      // 0: element tone, 1: gap after it
  logic       valid_q, valid_d;
  logic       key_q, key_d;
  logic [mse_pkg::DurW-1:0] dur_q, dur_d;
  logic       last_q, last_d;

  logic       out_free;
  logic       final_elem;
  logic       dah;
  logic       seg_key;
  logic       seg_last;
  logic [mse_pkg::DurW-1:0] dur1, dur3, dur4, seg_dur;

  assign out_free   = !valid_q || m_axis_tready;
  assign final_elem = (({1'b0, idx_q} + 3'd1) == cmd_q.len);
  assign dah        = cmd_q.bits[idx_q];

  assign dur1 = {2'b00, unit_ms_i};
  assign dur3 = {1'b0, unit_ms_i, 1'b0} + dur1;
  assign dur4 = {unit_ms_i, 2'b00};

  always_comb begin
    if (cmd_q.is_space) begin
      seg_key  = 1'b0;
      seg_dur  = dur4;
      seg_last = 1'b1;
    end else if (!gap_q) begin
      seg_key  = 1'b1;
      seg_dur  = dah ? dur3 : dur1;
      seg_last = 1'b0;
    end else begin
      seg_key  = 1'b0;
      seg_dur  = final_elem ? dur3 : dur1;
      seg_last = final_elem;
    end
  end

  always_comb begin
    cmd_d   = cmd_q;
    busy_d  = busy_q;
    idx_d   = idx_q;
    gap_d   = gap_q;
    valid_d = valid_q;
    key_d   = key_q;
    dur_d   = dur_q;
    last_d  = last_q;
    q_pop_o = 1'b0;

    if (out_free) begin
      valid_d = busy_q;
    end

    if (!busy_q) begin
      if (!q_empty_i) begin
        q_pop_o = 1'b1;
        cmd_d   = q_cmd_i;
        busy_d  = 1'b1;
        idx_d   = 2'd0;
        gap_d   = 1'b0;
      end
    end else if (out_free) begin
      key_d  = seg_key;
      dur_d  = seg_dur;
      last_d = seg_last;
      if (seg_last) begin
        busy_d = 1'b0;
      end else if (gap_q) begin
        idx_d = idx_q + 2'd1;
        gap_d = 1'b0;
      end else begin
        gap_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    gap_q  <= gap_d;
    key_q  <= key_d;
    dur_q  <= dur_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {3'b000, dur_q, key_q};
  assign m_axis_tlast  = last_q;

endmodule

// ===== verif/testbench.sv =====
// Self-checking stream testbench for the Morse segment encoder.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLen    = 300;   // receiver hold-off in the no-idle phase
  localparam int SettleCyc   = 40;    // quiet margin after the last segment
  localparam int EndWaitCyc  = 20000;

  // one expected key-line segment
  typedef struct packed {
    logic                     key_on;
    logic [mse_pkg::DurW-1:0] dur;
    logic                     last;
  } seg_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [mse_pkg::UnitW-1:0] cfg_wdata_i = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata = '0;    // [7:0] character
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [15:0]               m_axis_tdata;         // [0] key_on, [12:1] duration_ms
  logic                      m_axis_tlast;

  morse_segment_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  logic [7:0]                char_q [$];       // characters waiting to be offered
  seg_t                      seg_exp_q [$];    // segments owed by the block, oldest first
  logic [mse_pkg::UnitW-1:0] unit_now = mse_pkg::UnitReset;
  logic                      char_fire = 1'b0; // word taken at the last rising edge
  int                        send_idle_pct = 0;
  int                        recv_idle_pct = 0;
  logic                      long_stall = 1'b0;
  int                        stall_cycles = 0;
  int                        errors = 0;
  int                        chars_taken = 0;
  int                        segs_checked = 0;
  int                        unit_writes = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Dit/dah pattern of an uppercase letter; empty for anything else.
  function automatic string letter_code(input logic [7:0] ch);
    case (ch)
      "A": return ".-";    "B": return "-...";  "C": return "-.-.";  "D": return "-..";
      "E": return ".";     "F": return "..-.";  "G": return "--.";   "H": return "....";
      "I": return "..";    "J": return ".---";  "K": return "-.-";   "L": return ".-..";
      "M": return "--";    "N": return "-.";    "O": return "---";   "P": return ".--.";
      "Q": return "--.-";  "R": return ".-.";   "S": return "...";   "T": return "-";
      "U": return "..-";   "V": return "...-";  "W": return ".--";   "X": return "-..-";
      "Y": return "-.--";  "Z": return "--..";
      default: return "";
    endcase
  endfunction

  // Queue the segments one character must produce at the given unit length.
  task automatic predict_segments(input logic [7:0] ch,
                                  input logic [mse_pkg::UnitW-1:0] unit);
    string                    code;
    logic [mse_pkg::DurW-1:0] u1, u3, u4;
    logic                     final_el;
    code = letter_code(ch);
    u1 = mse_pkg::DurW'(unit);
    u3 = u1 * 12'd3;
    u4 = u1 * 12'd4;
    if (ch == mse_pkg::ChSpace) begin
      seg_exp_q.push_back('{key_on: 1'b0, dur: u4, last: 1'b1});
    end
    for (int i = 0; i < code.len(); i++) begin
      final_el = (i == code.len() - 1);
      seg_exp_q.push_back('{key_on: 1'b1, dur: (code[i] == "-") ? u3 : u1, last: 1'b0});
      seg_exp_q.push_back('{key_on: 1'b0, dur: final_el ? u3 : u1, last: final_el});
    end
  endtask

  // Sampling side: config shadow, accepted characters, segment compare.
  always @(posedge clk_i) begin
    seg_t exp_seg;
    if (rst_ni) begin
      if (cfg_we_i) begin
        unit_now = cfg_wdata_i;
      end
      char_fire = s_axis_tvalid && s_axis_tready;
      if (char_fire) begin
        chars_taken++;
        predict_segments(s_axis_tdata, unit_now);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        segs_checked++;
        if (seg_exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected segment key_on=%0b dur=%0d last=%0b", $time,
                   m_axis_tdata[0], m_axis_tdata[12:1], m_axis_tlast);
        end else begin
          exp_seg = seg_exp_q.pop_front();
          if (m_axis_tdata[0] !== exp_seg.key_on || m_axis_tdata[12:1] !== exp_seg.dur ||
              m_axis_tlast !== exp_seg.last) begin
            errors++;
            $display("%0t: mismatch exp key=%0b dur=%0d last=%0b got key=%0b dur=%0d last=%0b",
                     $time, exp_seg.key_on, exp_seg.dur, exp_seg.last,
                     m_axis_tdata[0], m_axis_tdata[12:1], m_axis_tlast);
          end
        end
      end
    end
  end

  // Character driver: holds a word until taken, then offers the next one or idles.
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !char_fire)) begin
      if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= char_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Segment sink: random backpressure, plus one long hold-off when requested.
  always @(negedge clk_i) begin
    if (long_stall && stall_cycles < StallLen) begin
      stall_cycles++;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Mostly letters and spaces, some arbitrary bytes.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) return mse_pkg::ChA + 8'($urandom_range(25));
    if (r < 80) return mse_pkg::ChSpace;
    return 8'($urandom_range(255));
  endfunction

  // Block idle: everything offered, taken and answered, and dropped words flushed.
  task automatic wait_idle();
    while (char_q.size() != 0 || s_axis_tvalid || seg_exp_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_unit(input logic [mse_pkg::UnitW-1:0] value);
    wait_idle();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    unit_writes++;
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      char_q.push_back(pick_char());
    end
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sender sparse-ish, receiver mostly stalled
    send_idle_pct = 33;
    recv_idle_pct = 85;

    // directed: empty and space, letter extremes, single- and four-element letters,
    // all-dah and mixed patterns, the range edges around A..Z and the byte extremes
    char_q = '{8'h00, mse_pkg::ChSpace, "A", "E", "T", "Z", "J", "Q", "Y", "H", "O", "S",
               mse_pkg::ChSpace, mse_pkg::ChSpace, "0", "a", "z", 8'h40, 8'h5B, 8'h1F,
               8'h21, 8'h60, 8'h7F, 8'h80, 8'hFF};

    write_unit(10'd1023);
    queue_random(50);
    wait_idle();

    send_idle_pct = 85;
    recv_idle_pct = 33;
    write_unit(10'd0);
    queue_random(40);
    write_unit(10'd1);
    queue_random(40);
    wait_idle();

    // no idling, but the sink holds off long enough to back the block up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_unit(10'd1000);
    long_stall = 1'b1;
    queue_random(40);
    write_unit(10'd1001);
    queue_random(40);
    write_unit(mse_pkg::UnitW'($urandom_range(1023)));
    queue_random(40);

    while (char_q.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    waited = 0;
    while (seg_exp_q.size() != 0 && waited < EndWaitCyc) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SettleCyc) @(negedge clk_i);
    if (seg_exp_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected segments never arrived", $time, seg_exp_q.size());
    end

    $display("Sent %0d characters over %0d unit settings, checked %0d segments.",
             chars_taken, unit_writes + 1, segs_checked);
    $display("Backpressure covered sparse, heavy, none and one %0d-cycle hold-off; %0d errors.",
             StallLen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mse_pkg.sv
hw/rtl/mse_front.sv
hw/rtl/mse_fifo.sv
hw/rtl/mse_back.sv
hw/rtl/morse_segment_encoder.sv
verif/testbench.sv
